/* sv/p2sb_pkg.sv */
package p2sb_pkg;

	localparam int unsigned NUM_BINS_DEF      = 2048;
	localparam int unsigned CORDIC_STAGES_DEF = 16;
	localparam int unsigned SQRT_ITERS        = 16;

	typedef struct packed {
		logic               req_type;
		logic signed [15:0] x_mm;
		logic signed [15:0] y_mm;
		logic signed [15:0] z_mm;
		logic [10:0]        bin_index;
	} item_t;

	typedef struct packed {
		logic [15:0] range_mm;
		logic        no_return;
		logic        point_binned;
	} result_t;

	typedef struct packed {
		logic signed [15:0] min_height_mm;
		logic signed [15:0] max_height_mm;
		logic [15:0]        range_min_mm;
		logic [15:0]        range_max_mm;
		logic signed [15:0] angle_lo;
		logic signed [15:0] angle_hi;
		logic [15:0]        bin_scale;
		logic [11:0]        bin_count;
	} cfg_t;

	typedef enum logic [2:0] {
		REG_MIN_HEIGHT = 3'd0,
		REG_MAX_HEIGHT = 3'd1,
		REG_RANGE_MIN  = 3'd2,
		REG_RANGE_MAX  = 3'd3,
		REG_ANGLE_LO   = 3'd4,
		REG_ANGLE_HI   = 3'd5,
		REG_BIN_SCALE  = 3'd6,
		REG_BIN_COUNT  = 3'd7
	} cfg_reg_t;

	// Item class decided at the front
	typedef enum logic [1:0] {
		CLS_ADD   = 2'd0,
		CLS_READ  = 2'd1,
		CLS_NORET = 2'd2,
		CLS_DROP  = 2'd3
	} cls_t;

	typedef struct packed {
		cls_t               cls;
		logic signed [15:0] x_mm;
		logic signed [15:0] y_mm;
		logic [10:0]        bin_index;
	} q_entry_t;

	typedef struct packed {
		logic clearing;
	} back_stat_t;

	// atan(2^-i) in binary angle units, 2^32 = one full turn
	function automatic logic [31:0] atan_lut(input logic [4:0] i);
		logic [31:0] v;
		unique case (i)
			5'd0:    v = 32'h20000000;
			5'd1:    v = 32'h12E4051E;
			5'd2:    v = 32'h09FB385B;
			5'd3:    v = 32'h051111D4;
			5'd4:    v = 32'h028B0D43;
			5'd5:    v = 32'h0145D7E1;
			5'd6:    v = 32'h00A2F61E;
			5'd7:    v = 32'h00517C55;
			5'd8:    v = 32'h0028BE53;
			5'd9:    v = 32'h00145F2F;
			5'd10:   v = 32'h000A2F98;
			5'd11:   v = 32'h000517CC;
			5'd12:   v = 32'h00028BE6;
			5'd13:   v = 32'h000145F3;
			5'd14:   v = 32'h0000A2FA;
			5'd15:   v = 32'h0000517D;
			5'd16:   v = 32'h000028BE;
			5'd17:   v = 32'h0000145F;
			5'd18:   v = 32'h00000A30;
			5'd19:   v = 32'h00000518;
			5'd20:   v = 32'h0000028C;
			5'd21:   v = 32'h00000146;
			5'd22:   v = 32'h000000A3;
			5'd23:   v = 32'h00000051;
			default: v = 32'h00000000;
		endcase
		return v;
	endfunction

endpackage

/* sv/p2sb_ram.sv */
module p2sb_ram #(
	parameter int unsigned WIDTH = 17,
	parameter int unsigned DEPTH = 2048
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* sv/p2sb_front.sv */
module p2sb_front #(
	parameter int unsigned NUM_BINS = p2sb_pkg::NUM_BINS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  p2sb_pkg::cfg_t       cfg,
	input  logic                 start,
	input  p2sb_pkg::item_t      item,
	input  p2sb_pkg::back_stat_t stat,
	input  logic                 pop,
	output logic                 busy,
	output logic                 head_valid,
	output p2sb_pkg::q_entry_t   head
);
	import p2sb_pkg::*;

	q_entry_t   q_mem [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	q_entry_t   entry;

	assign busy       = (cnt_q == 2'd2) || stat.clearing;
	assign push       = start && !busy;
	assign head_valid = (cnt_q != 2'd0);
	assign head       = q_mem[rd_ptr_q];

	always_comb begin
		entry.x_mm      = item.x_mm;
		entry.y_mm      = item.y_mm;
		entry.bin_index = item.bin_index;
		if (item.req_type) begin
			entry.cls = (32'(item.bin_index) >= NUM_BINS) ? CLS_NORET : CLS_READ;
		end else if (($signed(item.z_mm) < $signed(cfg.min_height_mm)) ||
		             ($signed(item.z_mm) > $signed(cfg.max_height_mm))) begin
			entry.cls = CLS_DROP;
		end else begin
			entry.cls = CLS_ADD;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

/* sv/p2sb_back.sv */
module p2sb_back #(
	parameter int unsigned NUM_BINS      = p2sb_pkg::NUM_BINS_DEF,
	parameter int unsigned CORDIC_STAGES = p2sb_pkg::CORDIC_STAGES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  p2sb_pkg::cfg_t       cfg,
	input  logic                 head_valid,
	input  p2sb_pkg::q_entry_t   head,
	output logic                 pop,
	output p2sb_pkg::back_stat_t stat,
	output logic                 done,
	output p2sb_pkg::result_t    result
);
	import p2sb_pkg::*;

	localparam int unsigned ABW   = $clog2(NUM_BINS);
	localparam int unsigned MAXIT = (CORDIC_STAGES > SQRT_ITERS) ? CORDIC_STAGES : SQRT_ITERS;
	localparam int unsigned CNTW  = $clog2(MAXIT);
	localparam int unsigned CXW   = 27;
	localparam int unsigned RAMW  = 17;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_SQUARE,
		S_LOAD,
		S_ITER,
		S_ROUND,
		S_WINDOW,
		S_BIN,
		S_RMW,
		S_RD_REQ,
		S_RD_RESP
	} state_t;

	state_t               state_q;
	logic [CNTW-1:0]      cnt_q;
	logic [ABW-1:0]       clr_q;
	logic [ABW-1:0]       addr_q;

	logic signed [15:0]   x_q;
	logic signed [15:0]   y_q;
	logic [31:0]          xx_q;
	logic [31:0]          yy_q;
	logic [31:0]          rem_q;
	logic [31:0]          root_q;
	logic [31:0]          bit_q;
	logic signed [CXW-1:0] cx_q;
	logic signed [CXW-1:0] cy_q;
	logic [31:0]          cz_q;
	logic                 orig_q;
	logic [15:0]          r_q;
	logic signed [15:0]   ang_q;
	logic [31:0]          prod_q;

	logic signed [31:0]   xw;
	logic signed [31:0]   yw;
	logic signed [CXW-1:0] xs;
	logic signed [CXW-1:0] ys;
	logic [31:0]          sq_try;
	logic                 sq_ge;
	logic                 sq_en;
	logic                 cd_en;
	logic signed [CXW-1:0] cdx;
	logic signed [CXW-1:0] cdy;
	logic [31:0]          atan;
	logic [31:0]          z_round;
	logic                 r_ok;
	logic                 a_ok;
	logic [15:0]          a_diff;
	logic [15:0]          bin16;
	logic                 bin_ok;
	logic [ABW-1:0]       bin_addr;

	logic                 we;
	logic [ABW-1:0]       waddr;
	logic [ABW-1:0]       raddr;
	logic [RAMW-1:0]      wdata;
	logic [RAMW-1:0]      rdata;
	logic                 rd_valid;
	logic [15:0]          rd_range;
	logic                 upd;

	// Each word holds {valid, range}
	p2sb_ram #(
		.WIDTH (RAMW),
		.DEPTH (NUM_BINS)
	) u_bins (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign pop           = (state_q == S_IDLE) && head_valid;
	assign stat.clearing = (state_q == S_CLEAR);

	assign xw      = 32'(x_q);
	assign yw      = 32'(y_q);
	assign xs      = CXW'(x_q) <<< 8;
	assign ys      = CXW'(y_q) <<< 8;

	assign sq_try  = root_q + bit_q;
	assign sq_ge   = rem_q >= sq_try;
	assign sq_en   = 32'(cnt_q) < SQRT_ITERS;
	assign cd_en   = 32'(cnt_q) < CORDIC_STAGES;
	assign cdx     = cy_q >>> cnt_q;
	assign cdy     = cx_q >>> cnt_q;
	assign atan    = atan_lut(5'(cnt_q));
	assign z_round = cz_q + 32'h0000_8000;

	assign r_ok    = (r_q >= cfg.range_min_mm) && (r_q <= cfg.range_max_mm);
	assign a_ok    = (ang_q >= $signed(cfg.angle_lo)) && (ang_q <= $signed(cfg.angle_hi));
	assign a_diff  = ang_q - $signed(cfg.angle_lo);

	assign bin16    = prod_q[31:16];
	assign bin_ok   = (bin16 < {4'd0, cfg.bin_count}) && (32'(bin16) < NUM_BINS);
	assign bin_addr = ABW'(bin16);

	assign rd_valid = rdata[16];
	assign rd_range = rdata[15:0];
	assign upd      = !rd_valid || (r_q < rd_range);

	always_comb begin
		we    = 1'b0;
		waddr = addr_q;
		wdata = '0;
		raddr = addr_q;
		unique case (state_q)
			S_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
			end
			S_BIN: begin
				raddr = bin_addr;
			end
			S_RD_RESP: begin
				we = 1'b1;
			end
			S_RMW: begin
				we    = upd;
				wdata = {1'b1, r_q};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			cnt_q   <= '0;
			done    <= 1'b0;
			result  <= '0;
		end else begin
			done   <= 1'b0;
			result <= '0;
			unique case (state_q)
				S_CLEAR: begin
					if (clr_q == ABW'(NUM_BINS - 1)) begin
						state_q <= S_IDLE;
					end else begin
						clr_q <= clr_q + ABW'(1);
					end
				end
				S_IDLE: begin
					if (head_valid) begin
						unique case (head.cls)
							CLS_ADD: begin
								state_q <= S_SQUARE;
							end
							CLS_READ: begin
								state_q <= S_RD_REQ;
							end
							CLS_NORET: begin
								done             <= 1'b1;
								result.no_return <= 1'b1;
							end
							CLS_DROP: begin
								done <= 1'b1;
							end
						endcase
					end
				end
				S_SQUARE: begin
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					cnt_q   <= '0;
					state_q <= S_ITER;
				end
				S_ITER: begin
					if (cnt_q == CNTW'(MAXIT - 1)) begin
						state_q <= S_ROUND;
					end else begin
						cnt_q <= cnt_q + CNTW'(1);
					end
				end
				S_ROUND: begin
					state_q <= S_WINDOW;
				end
				S_WINDOW: begin
					if (r_ok && a_ok) begin
						state_q <= S_BIN;
					end else begin
						done    <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_BIN: begin
					if (bin_ok) begin
						state_q <= S_RMW;
					end else begin
						done    <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_RMW: begin
					done                <= 1'b1;
					result.point_binned <= 1'b1;
					state_q             <= S_IDLE;
				end
				S_RD_REQ: begin
					state_q <= S_RD_RESP;
				end
				S_RD_RESP: begin
					done             <= 1'b1;
					result.range_mm  <= rd_valid ? rd_range : 16'd0;
					result.no_return <= !rd_valid;
					state_q          <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				x_q    <= head.x_mm;
				y_q    <= head.y_mm;
				addr_q <= ABW'(head.bin_index);
			end
			S_SQUARE: begin
				xx_q   <= xw * xw;
				yy_q   <= yw * yw;
				orig_q <= (x_q == 16'sd0) && (y_q == 16'sd0);
				// fold the left half plane into the right one
				if (xs < 0) begin
					if (ys >= 0) begin
						cx_q <= ys;
						cy_q <= -xs;
						cz_q <= 32'h4000_0000;
					end else begin
						cx_q <= -ys;
						cy_q <= xs;
						cz_q <= 32'hC000_0000;
					end
				end else begin
					cx_q <= xs;
					cy_q <= ys;
					cz_q <= 32'h0000_0000;
				end
			end
			S_LOAD: begin
				rem_q  <= xx_q + yy_q;
				root_q <= 32'd0;
				bit_q  <= 32'h4000_0000;
			end
			S_ITER: begin
				// one root digit and one rotation per cycle
				if (sq_en) begin
					if (sq_ge) begin
						rem_q  <= rem_q - sq_try;
						root_q <= (root_q >> 1) + bit_q;
					end else begin
						root_q <= root_q >> 1;
					end
					bit_q <= bit_q >> 2;
				end
				if (cd_en) begin
					if (cy_q < 0) begin
						cx_q <= cx_q - cdx;
						cy_q <= cy_q + cdy;
						cz_q <= cz_q - atan;
					end else begin
						cx_q <= cx_q + cdx;
						cy_q <= cy_q - cdy;
						cz_q <= cz_q + atan;
					end
				end
			end
			S_ROUND: begin
				r_q   <= root_q[15:0] + 16'(rem_q > root_q);
				ang_q <= orig_q ? 16'sd0 : $signed(z_round[31:16]);
			end
			S_WINDOW: begin
				prod_q <= {16'd0, a_diff} * {16'd0, cfg.bin_scale};
			end
			S_BIN: begin
				addr_q <= bin_addr;
			end
			default: begin
			end
		endcase
	end

endmodule

/* sv/point_to_scan_min_range_binner.sv */
// Order: a binned add item runs through the square, load, iterate, round, window, bin and
// read-modify-write states after it is taken; one failing the range or angle check ends in
// the window state, one failing the bin check in the bin state; a read item runs through a
// request and a response state; a point outside the height window or a read beyond the store
// ends in idle. The back end holds one item at a time; a two-beat queue absorbs short bursts.
// Reset: a clearing pass writes every bin with busy high; results cannot be stalled.
module point_to_scan_min_range_binner #(
	parameter int unsigned NUM_BINS      = p2sb_pkg::NUM_BINS_DEF,
	parameter int unsigned CORDIC_STAGES = p2sb_pkg::CORDIC_STAGES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  p2sb_pkg::item_t   item,
	output logic              done,
	output p2sb_pkg::result_t result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [15:0]       cfg_data
);
	import p2sb_pkg::*;

	cfg_t       cfg_q;
	back_stat_t stat;
	logic       pop;
	logic       head_valid;
	q_entry_t   head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_height_mm <= -16'sd1000;
			cfg_q.max_height_mm <= 16'sd1000;
			cfg_q.range_min_mm  <= 16'd0;
			cfg_q.range_max_mm  <= 16'd30000;
			cfg_q.angle_lo      <= 16'sh8000;
			cfg_q.angle_hi      <= 16'sh7FFF;
			cfg_q.bin_scale     <= 16'd1463;
			cfg_q.bin_count     <= 12'd1462;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_MIN_HEIGHT: cfg_q.min_height_mm <= cfg_data;
				REG_MAX_HEIGHT: cfg_q.max_height_mm <= cfg_data;
				REG_RANGE_MIN:  cfg_q.range_min_mm  <= cfg_data;
				REG_RANGE_MAX:  cfg_q.range_max_mm  <= cfg_data;
				REG_ANGLE_LO:   cfg_q.angle_lo      <= cfg_data;
				REG_ANGLE_HI:   cfg_q.angle_hi      <= cfg_data;
				REG_BIN_SCALE:  cfg_q.bin_scale     <= cfg_data;
				REG_BIN_COUNT:  cfg_q.bin_count     <= cfg_data[11:0];
			endcase
		end
	end

	p2sb_front #(
		.NUM_BINS (NUM_BINS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.start      (start),
		.item       (item),
		.stat       (stat),
		.pop        (pop),
		.busy       (busy),
		.head_valid (head_valid),
		.head       (head)
	);

	p2sb_back #(
		.NUM_BINS      (NUM_BINS),
		.CORDIC_STAGES (CORDIC_STAGES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.stat       (stat),
		.done       (done),
		.result     (result)
	);

endmodule

/* dv/tb_point_to_scan_min_range_binner.sv */
module tb_point_to_scan_min_range_binner;
	timeunit 1ns;
	timeprecision 1ps;

	import p2sb_pkg::*;

	localparam logic        REQ_ADD       = 1'b0;
	localparam logic        REQ_READ      = 1'b1;
	localparam int unsigned SCAN_BINS     = NUM_BINS_DEF;
	localparam int unsigned CORDIC_ITERS  = CORDIC_STAGES_DEF;
	localparam int          SETTLE_CYCLES = 40;

	// atan(2^-i), 2^32 per full turn
	localparam logic [31:0] ATAN_STEP [24] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        start     = 1'b0;
	logic        busy;
	item_t       item      = '0;
	logic        done;
	result_t     result;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data  = '0;

	item_t   stim_q[$];
	result_t scan_returns_q[$];
	logic    item_taken    = 1'b0;
	logic    steady_stream = 1'b0;
	int      mismatches    = 0;

	// scan state and register copy as the block should hold them
	cfg_t        reg_shadow;
	logic [15:0] bin_min [SCAN_BINS];
	bit          bin_hit [SCAN_BINS];

	int last_x;
	int last_y;
	bit have_last_pt = 1'b0;

	point_to_scan_min_range_binner dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic longint unsigned isqrt_round(longint unsigned n);
		longint unsigned root;
		longint unsigned probe;
		root  = 0;
		probe = 64'h1 << 62;
		while (probe > n) probe >>= 2;
		while (probe != 0) begin
			if (n >= root + probe) begin
				n    = n - (root + probe);
				root = (root >> 1) + probe;
			end else begin
				root >>= 1;
			end
			probe >>= 2;
		end
		// n is the remainder; round up past the midpoint
		if (n > root) root++;
		return root;
	endfunction

	function automatic logic signed [15:0] heading_of(longint px, longint py);
		longint      cx;
		longint      cy;
		longint      tx;
		longint      dx;
		longint      dy;
		logic [31:0] acc;
		if (px == 0 && py == 0) return '0;
		cx  = px * 256;
		cy  = py * 256;
		acc = '0;
		// fold the left half plane into the right one
		if (cx < 0) begin
			if (cy >= 0) begin
				tx  = cx;
				cx  = cy;
				cy  = -tx;
				acc = 32'h40000000;
			end else begin
				tx  = cx;
				cx  = -cy;
				cy  = tx;
				acc = 32'hC0000000;
			end
		end
		for (int i = 0; i < CORDIC_ITERS && i < 24; i++) begin
			dx = cy >>> i;
			dy = cx >>> i;
			if (cy < 0) begin
				cx  = cx - dx;
				cy  = cy + dy;
				acc = acc - ATAN_STEP[i];
			end else begin
				cx  = cx + dx;
				cy  = cy - dy;
				acc = acc + ATAN_STEP[i];
			end
		end
		acc = acc + 32'h8000;
		return acc[31:16];
	endfunction

	function automatic result_t predict_scan_return(item_t it);
		result_t ret;
		longint  px;
		longint  py;
		longint  pz;
		longint  rng;
		longint  ang;
		longint  lo;
		longint  bin_no;
		ret = '0;
		if (it.req_type == REQ_READ) begin
			if (it.bin_index >= SCAN_BINS) begin
				ret.no_return = 1'b1;
			end else begin
				if (bin_hit[it.bin_index]) ret.range_mm = bin_min[it.bin_index];
				else ret.no_return = 1'b1;
				bin_hit[it.bin_index] = 1'b0;
			end
			return ret;
		end
		px = $signed(it.x_mm);
		py = $signed(it.y_mm);
		pz = $signed(it.z_mm);
		if (pz < longint'($signed(reg_shadow.min_height_mm)) ||
		    pz > longint'($signed(reg_shadow.max_height_mm))) return ret;
		rng = longint'(isqrt_round(px * px + py * py));
		if (rng < longint'(reg_shadow.range_min_mm) ||
		    rng > longint'(reg_shadow.range_max_mm)) return ret;
		ang = heading_of(px, py);
		lo  = $signed(reg_shadow.angle_lo);
		if (ang < lo || ang > longint'($signed(reg_shadow.angle_hi))) return ret;
		bin_no = ((ang - lo) * longint'(reg_shadow.bin_scale)) >> 16;
		if (bin_no >= longint'(reg_shadow.bin_count) || bin_no >= SCAN_BINS) return ret;
		if (!bin_hit[bin_no] || rng < longint'(bin_min[bin_no])) begin
			bin_min[bin_no] = rng[15:0];
			bin_hit[bin_no] = 1'b1;
		end
		ret.point_binned = 1'b1;
		return ret;
	endfunction

	function automatic int pick_between(int lo, int hi);
		return lo + int'($urandom_range(hi - lo));
	endfunction

	function automatic item_t point_item(int px, int py, int pz);
		item_t it;
		it          = '0;
		it.req_type = REQ_ADD;
		it.x_mm     = 16'(px);
		it.y_mm     = 16'(py);
		it.z_mm     = 16'(pz);
		return it;
	endfunction

	function automatic item_t read_item(int idx);
		item_t it;
		it           = '0;
		it.req_type  = REQ_READ;
		it.bin_index = 11'(idx);
		return it;
	endfunction

	function automatic item_t make_scan_item();
		item_t it;
		int    roll;
		int    span;
		int    top;
		int    hx;
		int    hy;
		it.req_type  = REQ_ADD;
		it.x_mm      = 16'($urandom);
		it.y_mm      = 16'($urandom);
		it.z_mm      = 16'($urandom);
		it.bin_index = 11'($urandom);
		if ($urandom_range(99) < 30) begin
			it.req_type = REQ_READ;
			if (reg_shadow.bin_count == 0) top = 0;
			else if (reg_shadow.bin_count > SCAN_BINS) top = SCAN_BINS - 1;
			else top = reg_shadow.bin_count - 1;
			// mostly read bins in use, where points land
			if ($urandom_range(4) != 0) it.bin_index = 11'($urandom_range(top));
			return it;
		end
		if ($urandom_range(99) < 85 &&
		    $signed(reg_shadow.min_height_mm) <= $signed(reg_shadow.max_height_mm))
			it.z_mm = 16'(pick_between($signed(reg_shadow.min_height_mm),
			                           $signed(reg_shadow.max_height_mm)));
		case ($urandom_range(3))
			0:       span = 100;
			1:       span = 2000;
			2:       span = 20000;
			default: span = 32767;
		endcase
		roll = $urandom_range(99);
		if (roll < 15 && have_last_pt) begin
			// last point, each coordinate kept or halved: same or shorter range, same heading if both match
			hx = last_x >>> $urandom_range(1);
			hy = last_y >>> $urandom_range(1);
		end else if (roll < 45) begin
			hx = pick_between(1, span);
			hy = pick_between(0, hx / 2);
		end else if (roll < 90) begin
			hx = pick_between(-span, span);
			hy = pick_between(-span, span);
		end else begin
			hx = $signed(it.x_mm);
			hy = $signed(it.y_mm);
		end
		it.x_mm      = 16'(hx);
		it.y_mm      = 16'(hy);
		last_x       = hx;
		last_y       = hy;
		have_last_pt = 1'b1;
		return it;
	endfunction

	task automatic queue_random(int count);
		repeat (count) stim_q.push_back(make_scan_item());
	endtask

	task automatic drain_scan();
		while (stim_q.size() != 0 || start) @(posedge clk);
		while (scan_returns_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic program_regs(input logic [15:0] v_min_h, input logic [15:0] v_max_h,
	                            input logic [15:0] v_rmin, input logic [15:0] v_rmax,
	                            input logic [15:0] v_alo, input logic [15:0] v_ahi,
	                            input logic [15:0] v_scale, input logic [15:0] v_count);
		logic [15:0] vals [8];
		cfg_reg_t    code;
		vals = '{v_min_h, v_max_h, v_rmin, v_rmax, v_alo, v_ahi, v_scale, v_count};
		for (int i = 0; i < 8; i++) begin
			code = cfg_reg_t'(i);
			@(negedge clk);
			cfg_valid <= 1'b1;
			cfg_index <= code;
			cfg_data  <= vals[i];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			case (code)
				REG_MIN_HEIGHT: reg_shadow.min_height_mm = vals[i];
				REG_MAX_HEIGHT: reg_shadow.max_height_mm = vals[i];
				REG_RANGE_MIN:  reg_shadow.range_min_mm  = vals[i];
				REG_RANGE_MAX:  reg_shadow.range_max_mm  = vals[i];
				REG_ANGLE_LO:   reg_shadow.angle_lo      = vals[i];
				REG_ANGLE_HI:   reg_shadow.angle_hi      = vals[i];
				REG_BIN_SCALE:  reg_shadow.bin_scale     = vals[i];
				REG_BIN_COUNT:  reg_shadow.bin_count     = vals[i][11:0];
				default: ;
			endcase
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	always @(negedge clk) begin : driver
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!start || item_taken) begin
			if (stim_q.size() != 0 && (steady_stream || $urandom_range(99) >= 17)) begin
				start <= 1'b1;
				item  <= stim_q.pop_front();
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : intake
		item_taken <= arst_n && start && !busy;
		if (arst_n && start && !busy) scan_returns_q.push_back(predict_scan_return(item));
	end

	always @(posedge clk) begin : monitor
		result_t want;
		if (arst_n && done) begin
			if (scan_returns_q.size() == 0) begin
				$error("result beat with nothing expected: range_mm %0d no_return %0b point_binned %0b",
				       result.range_mm, result.no_return, result.point_binned);
				mismatches++;
			end else begin
				want = scan_returns_q.pop_front();
				if (result.range_mm !== want.range_mm) begin
					$error("range_mm: expected %0d, got %0d", want.range_mm, result.range_mm);
					mismatches++;
				end
				if (result.no_return !== want.no_return) begin
					$error("no_return: expected %0b, got %0b", want.no_return, result.no_return);
					mismatches++;
				end
				if (result.point_binned !== want.point_binned) begin
					$error("point_binned: expected %0b, got %0b",
					       want.point_binned, result.point_binned);
					mismatches++;
				end
			end
		end
	end

	initial begin : stimulus
		reg_shadow.min_height_mm = 16'hFC18;
		reg_shadow.max_height_mm = 16'd1000;
		reg_shadow.range_min_mm  = 16'd0;
		reg_shadow.range_max_mm  = 16'd30000;
		reg_shadow.angle_lo      = 16'h8000;
		reg_shadow.angle_hi      = 16'h7FFF;
		reg_shadow.bin_scale     = 16'd1463;
		reg_shadow.bin_count     = 12'd1462;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(posedge clk);
		// hold off while the bins are cleared
		while (busy) @(posedge clk);

		// directed, at reset settings
		stim_q.push_back(point_item(0, 0, 0));
		stim_q.push_back(read_item(731));
		stim_q.push_back(read_item(731));
		stim_q.push_back(point_item(300, 400, 1000));
		stim_q.push_back(point_item(300, 400, -1000));
		stim_q.push_back(point_item(600, 800, 0));
		stim_q.push_back(point_item(150, 200, 0));
		stim_q.push_back(read_item(946));
		stim_q.push_back(read_item(947));
		stim_q.push_back(read_item(948));
		stim_q.push_back(point_item(5, 5, 1001));
		stim_q.push_back(point_item(5, 5, -1001));
		stim_q.push_back(point_item(5, 5, 32767));
		stim_q.push_back(point_item(5, 5, -32768));
		stim_q.push_back(point_item(32767, 0, 0));
		stim_q.push_back(point_item(-32768, -32768, 0));
		stim_q.push_back(point_item(30000, 0, 0));
		stim_q.push_back(point_item(-100, 0, 0));
		stim_q.push_back(point_item(-100, 1, 0));
		stim_q.push_back(point_item(0, -30000, 0));
		stim_q.push_back(point_item(-32768, 32767, 0));
		stim_q.push_back(read_item(0));
		stim_q.push_back(read_item(1500));
		stim_q.push_back(read_item(2047));
		queue_random(110);
		// pause until every result is back, then resume
		drain_scan();
		queue_random(110);
		drain_scan();

		// widest windows, one bin per 32 angle units over the full store
		program_regs(16'h8000, 16'h7FFF, 16'd0, 16'hFFFF, 16'h8000, 16'h7FFF, 16'd2048, 16'd2048);
		steady_stream = 1'b1;
		queue_random(120);
		while (stim_q.size() != 0) @(posedge clk);
		steady_stream = 1'b0;
		queue_random(80);
		drain_scan();

		// narrow sector, fine bins running past the store
		program_regs(16'hFFCE, 16'd50, 16'd100, 16'd5000, 16'd0, 16'd4000, 16'hFFFF, 16'hFFFF);
		queue_random(120);
		drain_scan();

		// every window inverted, no bins in use
		program_regs(16'd10, 16'hFFF6, 16'd40000, 16'd100, 16'd5, 16'hFFFB, 16'd300, 16'hF000);
		queue_random(40);
		drain_scan();

		// a single bin takes every point
		program_regs(16'h8000, 16'h7FFF, 16'd0, 16'hFFFF, 16'h8000, 16'h7FFF, 16'd1, 16'd1);
		queue_random(80);
		drain_scan();

		// back to the reset settings
		program_regs(16'hFC18, 16'd1000, 16'd0, 16'd30000, 16'h8000, 16'h7FFF, 16'd1463, 16'd1462);
		queue_random(60);
		drain_scan();

		if (mismatches == 0) begin
			$display("tb_point_to_scan_min_range_binner passed");
		end else begin
			$display("tb_point_to_scan_min_range_binner failed");
		end
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("tb_point_to_scan_min_range_binner failed");
		$finish;
	end

endmodule
